// ===== src/cst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and arithmetic helpers
// Holds the payload word types, order codes and fixed-point helpers used by
// the front and back parts of the transform composition unit.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QUAT_FRAC = 30;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = 1;

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [34:0] QONE = 35'sd1 <<< QUAT_FRAC;

    typedef enum logic [2:0] {
        ORD_SRT = 3'd0,
        ORD_STR = 3'd1,
        ORD_RST = 3'd2,
        ORD_RTS = 3'd3,
        ORD_TSR = 3'd4,
        ORD_TRS = 3'd5,
        ORD_X6  = 3'd6,
        ORD_X7  = 3'd7
    } t_order;

    typedef enum logic [1:0] {
        MAT_S = 2'd0,
        MAT_R = 2'd1,
        MAT_T = 2'd2
    } t_mat_sel;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic [2:0]         order;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last;
    } t_out_word;

    // Front-to-back queue entry: three matrices already selected in order.
    typedef struct packed {
        logic signed [15:0][31:0] ma;
        logic signed [15:0][31:0] mb;
        logic signed [15:0][31:0] mc;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Round-half-up shift of a 64-bit product by FRAC_BITS.
    function automatic logic signed [47:0] rnd_prod(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (64'sd1 <<< (FRAC_BITS - 1));
        return 48'(t >>> FRAC_BITS);
    endfunction

    function automatic t_mat_sel order_slot(input logic [2:0] ord, input int k);
        t_mat_sel r;
        case (ord)
            ORD_STR: r = (k == 0) ? MAT_S : (k == 1) ? MAT_T : MAT_R;
            ORD_RST: r = (k == 0) ? MAT_R : (k == 1) ? MAT_S : MAT_T;
            ORD_RTS: r = (k == 0) ? MAT_R : (k == 1) ? MAT_T : MAT_S;
            ORD_TSR: r = (k == 0) ? MAT_T : (k == 1) ? MAT_S : MAT_R;
            ORD_TRS: r = (k == 0) ? MAT_T : (k == 1) ? MAT_R : MAT_S;
            default: r = (k == 0) ? MAT_S : (k == 1) ? MAT_R : MAT_T;
        endcase
        return r;
    endfunction

endpackage

// ===== src/cst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_front: input stage and rotation builder
// Registers each word, forms the quaternion products in a second stage and
// builds the S, R and T matrices, ordered by the order code, in a third.
// ----------------------------------------------------------------------------
module cst_front
    import cst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_job     o_job
);

    logic             r_v1, r_v2, r_v3;
    t_in_word         r_d1, r_d2;
    logic signed [34:0] r_p [9];
    t_job             r_job;
    logic             adv3, adv2, adv1;
    logic signed [35:0] rr [9];
    logic signed [15:0][31:0] m [3];

    assign adv3 = !r_v3 || i_ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v3;
    assign o_job = r_job;

    function automatic logic signed [34:0] tw(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + (64'sd1 <<< (QUAT_FRAC - 2));
        return 35'(p >>> (QUAT_FRAC - 1));
    endfunction

    always_comb begin
        logic signed [35:0] t;
        rr[0] = QONE - r_p[0] - r_p[1];
        rr[1] = r_p[2] + r_p[3];
        rr[2] = r_p[4] - r_p[5];
        rr[3] = r_p[2] - r_p[3];
        rr[4] = QONE - r_p[6] - r_p[1];
        rr[5] = r_p[7] + r_p[8];
        rr[6] = r_p[4] + r_p[5];
        rr[7] = r_p[7] - r_p[8];
        rr[8] = QONE - r_p[6] - r_p[0];
        for (int k = 0; k < 3; k++) begin
            for (int e = 0; e < 16; e++) begin
                m[k][e] = (e % 5 == 0) ? ONE_FX : 32'sd0;
            end
        end
        m[MAT_S][0]  = r_d2.scale_x;
        m[MAT_S][5]  = r_d2.scale_y;
        m[MAT_S][10] = r_d2.scale_z;
        m[MAT_T][12] = r_d2.trans_x;
        m[MAT_T][13] = r_d2.trans_y;
        m[MAT_T][14] = r_d2.trans_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                t = (rr[i*3+j] + (36'sd1 <<< (QUAT_FRAC - FRAC_BITS - 1)))
                    >>> (QUAT_FRAC - FRAC_BITS);
                m[MAT_R][i*4+j] = sat32(50'(t));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
        if (adv1 && i_valid) r_d1 <= i_data;
        if (adv2 && r_v1) begin
            r_d2 <= r_d1;
            r_p[0] <= tw(r_d1.quat_y, r_d1.quat_y);
            r_p[1] <= tw(r_d1.quat_z, r_d1.quat_z);
            r_p[2] <= tw(r_d1.quat_x, r_d1.quat_y);
            r_p[3] <= tw(r_d1.quat_w, r_d1.quat_z);
            r_p[4] <= tw(r_d1.quat_x, r_d1.quat_z);
            r_p[5] <= tw(r_d1.quat_w, r_d1.quat_y);
            r_p[6] <= tw(r_d1.quat_x, r_d1.quat_x);
            r_p[7] <= tw(r_d1.quat_y, r_d1.quat_z);
            r_p[8] <= tw(r_d1.quat_w, r_d1.quat_x);
        end
        if (adv3 && r_v2) begin
            r_job.ma <= m[order_slot(r_d2.order, 0)];
            r_job.mb <= m[order_slot(r_d2.order, 1)];
            r_job.mc <= m[order_slot(r_d2.order, 2)];
        end
    end

endmodule

// ===== src/cst_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_fifo: job queue
// A short register queue that lets the front and back parts stall apart.
// ----------------------------------------------------------------------------
module cst_fifo
    import cst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_data
);

    t_job             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic             wr, rd;

    assign o_ready = (r_cnt != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(wr) - (FIFO_AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== src/cst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_back: row-serial matrix product
// Takes one job, computes one row of A*B into a register, then one row of
// (A*B)*C per cycle unless output stalls, four multipliers per row column set.
// ----------------------------------------------------------------------------
module cst_back
    import cst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    // Stage 1 computes rows of AB, stage 2 rows of (AB)C, pipelined by row.
    logic             r_busy;
    logic [1:0]       r_row1;
    logic signed [15:0][31:0] r_b, r_c, r_a;
    logic             r_v2;
    logic [1:0]       r_row2;
    logic signed [3:0][31:0] r_ab;
    logic signed [15:0][31:0] r_c2;
    logic             r_vo;
    t_out_word        r_out;
    logic             adv_o, adv2, adv1;
    logic signed [3:0][31:0] ab_row, res_row;

    assign adv_o = !r_vo || i_ready;
    assign adv2  = !r_v2 || adv_o;
    assign adv1  = adv2;
    assign o_ready = adv1 && (!r_busy || r_row1 == 2'd3);
    assign o_valid = r_vo;
    assign o_data  = r_out;

    always_comb begin
        logic signed [49:0] acc;
        for (int k = 0; k < 4; k++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
                acc = acc + 50'(rnd_prod($signed(r_a[r_row1*4+j]) *
                                         $signed(r_b[j*4+k])));
            end
            ab_row[k] = sat32(acc);
        end
        for (int k = 0; k < 4; k++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
                acc = acc + 50'(rnd_prod($signed(r_ab[j]) * $signed(r_c2[j*4+k])));
            end
            res_row[k] = sat32(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row1 <= '0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv1) begin
                if (i_valid && o_ready) begin
                    r_busy <= 1'b1;
                    r_row1 <= '0;
                end else if (r_busy) begin
                    r_busy <= (r_row1 != 2'd3);
                    r_row1 <= r_row1 + 2'd1;
                end
            end
            if (adv2) r_v2 <= r_busy;
            if (adv_o) r_vo <= r_v2;
        end
        if (i_valid && o_ready) begin
            r_a <= i_job.ma;
            r_b <= i_job.mb;
            r_c <= i_job.mc;
        end
        if (adv2 && r_busy) begin
            r_ab <= ab_row;
            r_row2 <= r_row1;
            r_c2 <= r_c;
        end
        if (adv_o && r_v2) begin
            r_out.row  <= r_row2;
            r_out.col0 <= res_row[0];
            r_out.col1 <= res_row[1];
            r_out.col2 <= res_row[2];
            r_out.col3 <= res_row[3];
            r_out.last <= (r_row2 == 2'd3);
        end
    end

endmodule

// ===== src/compose_srt_transform_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compose_srt_transform_unit: scale/rotate/translate matrix composer
// Builds a 4x4 affine matrix from translation, quaternion and scale words.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per transform: translation and scale in
// Q16.16, quaternion in Q1.30, and an order code. The output channel gives
// four words per transform, rows 0 to 3 top first, last set on row 3.
// The first row passes the builder's stages, the queue, and the product
// unit's job, AB-row and output registers before it is presented.
// The row-serial product unit emits one row per cycle unless the output
// stalls, and takes the next job while it forms the last row of the current.
// A two-entry queue separates the matrix builder from the product unit, so
// the builder keeps taking words while the receiver stalls, until the queue
// and the builder's own stages fill; then input ready drops. Rows are held
// stable while stalled. Synchronous reset empties all stages and the queue;
// no result is lost across a stall.
// ----------------------------------------------------------------------------
module compose_srt_transform_unit
    import cst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic f_valid, f_ready, b_valid, b_ready;
    t_job f_job, b_job;

    cst_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(f_valid), .i_ready(f_ready), .o_job(f_job)
    );

    cst_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_job),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(b_job)
    );

    cst_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready), .i_job(b_job),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

endmodule

// ===== src/cst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker: port-level checks
// Watches the top-level ports for row ordering and handshake behavior.
// ----------------------------------------------------------------------------
module cst_checker
    import cst_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    logic [1:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (o_valid && i_ready) begin
            r_exp <= r_exp + 2'd1;
        end
    end

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.row == r_exp) else $error("row out of order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.last == (o_data.row == 2'd3)) else $error("bad last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("word dropped");

endmodule

bind compose_srt_transform_unit cst_checker u_cst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
